// File: sv/thbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thbp_pkg
// Shared types and constants for the threshold / 1bpp packing block.
// ----------------------------------------------------------------------------
package thbp_pkg;

    // Column counter width default
    localparam int COLUMN_BITS_DEF = 16;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH = 4'd1;

    // Register reset values
    localparam logic [7:0]  THRESHOLD_RESET = 8'd127;
    localparam logic [15:0] ROW_WIDTH_RESET = 16'd1;

    // Byte-count field width: one data byte plus up to three padding bytes
    localparam int BURST_W = 3;

    // Burst of output bytes produced by one pixel
    typedef struct packed {
        logic               valid;
        logic [7:0]         data;
        logic [BURST_W-1:0] count;
        logic               row_end;
    } burst_t;

endpackage
`default_nettype wire

// File: sv/thbp_pack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thbp_pack
// Thresholds one pixel, packs its bit MSB first and tracks row position;
// describes the output bytes the pixel causes as one burst.
// ----------------------------------------------------------------------------
module thbp_pack #(
    parameter int COLUMN_BITS = thbp_pkg::COLUMN_BITS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [31:0]     pixel_word,
    input  wire logic            accept,
    input  wire logic [7:0]      threshold,
    input  wire logic [15:0]     row_width,
    output thbp_pkg::burst_t     burst
);
    import thbp_pkg::*;

    logic [COLUMN_BITS-1:0] column_reg, column_next;
    logic [2:0]             bit_pos_reg, bit_pos_next;
    logic [7:0]             partial_reg, partial_next;
    logic [1:0]             mod4_reg, mod4_next;

    logic [9:0]             chan_sum;
    logic [9:0]             limit;
    logic                   hit;
    logic [7:0]             packed_byte;
    logic [COLUMN_BITS-1:0] column_inc;
    logic [COLUMN_BITS-1:0] width_cmp;
    logic                   row_done;
    logic                   data_emit;
    logic [1:0]             mod4_after;
    logic [1:0]             pad_count;

    // Average above threshold: sum/3 > t  <=>  sum > 3t + 2
    assign chan_sum = 10'(pixel_word[15:8]) + 10'(pixel_word[23:16])
                    + 10'(pixel_word[31:24]);
    assign limit    = {1'b0, threshold, 1'b0} + 10'(threshold) + 10'd2;
    assign hit      = chan_sum > limit;

    // Insert the pixel bit into the byte under assembly
    assign packed_byte = partial_reg | (8'(hit) << bit_pos_reg);

    // Row position, compared within the counter width
    assign column_inc = column_reg + COLUMN_BITS'(1);
    assign width_cmp  = COLUMN_BITS'(row_width);
    assign row_done   = column_inc == width_cmp;

    // A data byte leaves when full or flushed at row end
    assign data_emit  = (bit_pos_reg == 3'd0) || row_done;
    assign mod4_after = mod4_reg + 2'(data_emit);
    assign pad_count  = row_done ? (2'd0 - mod4_after) : 2'd0;

    always_comb
    begin
        burst.valid   = data_emit;
        burst.data    = packed_byte;
        burst.count   = BURST_W'(data_emit) + BURST_W'(pad_count);
        burst.row_end = row_done;
    end

    // Advance packing state for each accepted pixel
    always_comb
    begin
        partial_next = data_emit ? 8'd0 : packed_byte;
        bit_pos_next = data_emit ? 3'd7 : bit_pos_reg - 3'd1;
        column_next  = row_done ? '0 : column_inc;
        mod4_next    = row_done ? 2'd0 : mod4_after;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg  <= '0;
            bit_pos_reg <= 3'd7;
            partial_reg <= 8'd0;
            mod4_reg    <= 2'd0;
        end
        else if (accept)
        begin
            column_reg  <= column_next;
            bit_pos_reg <= bit_pos_next;
            partial_reg <= partial_next;
            mod4_reg    <= mod4_next;
        end
    end

    // A fresh byte has no bits set yet
    a_fresh_byte_clear: assert property (@(posedge clk) disable iff (!rst_n)
        bit_pos_reg == 3'd7 |-> partial_reg == 8'd0)
        else $error("partial byte not clear at start of byte");

endmodule
`default_nettype wire

// File: sv/thbp_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thbp_emit
// Output stage: holds the current burst and one pending burst, and plays
// each burst out as a data byte followed by zero padding bytes.
// ----------------------------------------------------------------------------
module thbp_emit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire thbp_pkg::burst_t burst,
    input  wire logic             accept,
    output logic                  in_ready,
    output logic [7:0]            out_byte,
    output logic                  row_end,
    output logic                  last_of_run,
    output logic                  out_valid,
    input  wire logic             out_ready
);
    import thbp_pkg::*;

    logic               cur_valid_reg;
    logic [7:0]         cur_byte_reg;
    logic [BURST_W-1:0] cur_count_reg;
    logic               cur_row_end_reg;
    logic               pend_valid_reg;
    logic [7:0]         pend_byte_reg;
    logic [BURST_W-1:0] pend_count_reg;
    logic               pend_row_end_reg;

    logic               load;
    logic               take;
    logic               last;
    logic               cur_free;

    assign load     = accept && burst.valid;
    assign take     = cur_valid_reg && out_ready;
    assign last     = cur_count_reg == BURST_W'(1);
    assign cur_free = !cur_valid_reg || (take && last);

    assign in_ready    = !pend_valid_reg;
    assign out_valid   = cur_valid_reg;
    assign out_byte    = cur_byte_reg;
    assign last_of_run = last;
    assign row_end     = cur_row_end_reg && last;

    // Control: refill the current burst from pending or new, else advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (cur_free)
        begin
            if (pend_valid_reg)
            begin
                cur_valid_reg  <= 1'b1;
                pend_valid_reg <= load;
            end
            else
            begin
                cur_valid_reg <= load;
            end
        end
        else if (load)
        begin
            pend_valid_reg <= 1'b1;
        end
    end

    // Payload: move bursts along, zero the byte after the data transfer
    always_ff @(posedge clk)
    begin
        if (cur_free)
        begin
            if (pend_valid_reg)
            begin
                cur_byte_reg     <= pend_byte_reg;
                cur_count_reg    <= pend_count_reg;
                cur_row_end_reg  <= pend_row_end_reg;
                pend_byte_reg    <= burst.data;
                pend_count_reg   <= burst.count;
                pend_row_end_reg <= burst.row_end;
            end
            else
            begin
                cur_byte_reg    <= burst.data;
                cur_count_reg   <= burst.count;
                cur_row_end_reg <= burst.row_end;
            end
        end
        else
        begin
            if (take)
            begin
                cur_byte_reg  <= 8'd0;
                cur_count_reg <= cur_count_reg - BURST_W'(1);
            end
            if (load)
            begin
                pend_byte_reg    <= burst.data;
                pend_count_reg   <= burst.count;
                pend_row_end_reg <= burst.row_end;
            end
        end
    end

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> cur_count_reg != '0)
        else $error("active burst with zero byte count");

    a_padding_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !last) |=> (cur_valid_reg && out_byte == 8'd0))
        else $error("padding byte not zero");

    a_row_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && row_end) |-> last_of_run)
        else $error("row end on a byte that does not close its burst");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> cur_valid_reg)
        else $error("pending burst without a current burst");

endmodule
`default_nettype wire

// File: sv/threshold_binarize_pack_1bpp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// threshold_binarize_pack_1bpp
// Thresholds 32-bit pixels against a brightness level and packs them into
// 1bpp rows, each row padded with zero bytes to a multiple of four bytes.
// ----------------------------------------------------------------------------
// Output: a pixel's burst is registered into the output byte register, or into
//   the pending buffer while that register is busy. Throughput: one pixel per
//   cycle while the pending buffer is empty; a burst of N bytes (N up to 4 at a
//   row end) holds the single output byte register until all N are taken.
// Reset: packing state cleared (bit position 7), threshold 127, row width 1,
//   output empty; no clearing pass.
module threshold_binarize_pack_1bpp #(
    parameter int COLUMN_BITS = thbp_pkg::COLUMN_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [thbp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [thbp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [31:0]                 pixel_word,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [7:0]                       out_byte,
    output logic                             row_end,
    output logic                             last_of_run
);
    import thbp_pkg::*;

    logic [7:0]  threshold_reg;
    logic [15:0] row_width_reg;
    logic        accept;
    burst_t      burst;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    // Decode register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            row_width_reg <= ROW_WIDTH_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_data[7:0];
                REG_ROW_WIDTH: row_width_reg <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    // Threshold and pack
    thbp_pack #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_pack (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_word (pixel_word),
        .accept     (accept),
        .threshold  (threshold_reg),
        .row_width  (row_width_reg),
        .burst      (burst)
    );

    // Play out byte bursts
    thbp_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst       (burst),
        .accept      (accept),
        .in_ready    (in_ready),
        .out_byte    (out_byte),
        .row_end     (row_end),
        .last_of_run (last_of_run),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

endmodule
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - threshold_binarize_pack_1bpp testbench
// Streams pixel words and register writes into the block and checks every
// packed row byte against a cycle-free model of the thresholding and 1bpp
// packing: MSB-first bit fill, partial byte flush at row end, zero padding
// to a four-byte row, and the row_end / last_of_run markers. Both sides of
// the stream idle at random. Row widths are raised mid-row, ahead of the
// current column.
// ----------------------------------------------------------------------------
module tb;

    import thbp_pkg::*;

    localparam int COL_W         = COLUMN_BITS_DEF;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_PIXELS = 420;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_FIRST = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LAST  = 4'hF;

    typedef enum logic [1:0] {
        JOB_PIXEL,
        JOB_WRITE,
        JOB_DRAIN
    } job_kind_e;

    typedef struct {
        job_kind_e               kind;
        logic [CFG_INDEX_W-1:0]  index;
        logic [31:0]             data;
        int                      gap;
    } stim_job_t;

    typedef struct {
        logic [7:0] data;
        logic       row_end;
        logic       last_of_run;
    } row_byte_t;

    // DUT ports
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [31:0]            pixel_word = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [7:0]             out_byte;
    logic                   row_end;
    logic                   last_of_run;

    // Stimulus and expected bytes
    stim_job_t  jobs[$];
    row_byte_t  expected_bytes[$];

    // Packing model state
    logic [7:0]       mdl_level = THRESHOLD_RESET;
    logic [15:0]      mdl_width = ROW_WIDTH_RESET;
    logic [COL_W-1:0] mdl_col   = '0;
    logic [2:0]       mdl_bit   = 3'd7;
    logic [7:0]       mdl_acc   = '0;
    logic [1:0]       mdl_mod4  = '0;

    // Generator tracking, so width changes stay ahead of the column
    logic [7:0]       gen_level = THRESHOLD_RESET;
    logic [15:0]      gen_width = ROW_WIDTH_RESET;
    logic [COL_W-1:0] gen_col   = '0;
    bit               tx_calm   = 1'b0;
    bit               rx_calm   = 1'b0;

    // Driver and monitor bookkeeping
    int hold       = 0;
    int hold_after = 0;
    int quiet      = 0;
    int stall      = 0;
    int mismatches = 0;
    int pixels_sent = 0;
    int writes_done = 0;
    int bytes_checked = 0;
    int rows_seen  = 0;
    int drains     = 0;

    threshold_binarize_pack_1bpp dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_word  (pixel_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .row_end     (row_end),
        .last_of_run (last_of_run)
    );

    // Clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Idle length for one transfer; calm stretches give back-to-back traffic
    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 17);
    endfunction

    // Pixel whose channels sit around the given level
    function automatic logic [31:0] near_level(input logic [7:0] lvl);
        logic [31:0] word;
        int          ch;
        word = $urandom;
        for (int k = 1; k < 4; k++)
        begin
            ch = int'(lvl) + $urandom_range(0, 6) - 3;
            if (ch < 0)
                ch = 0;
            if (ch > 255)
                ch = 255;
            word[k*8 +: 8] = 8'(ch);
        end
        return word;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("ERROR @%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Packing model
    // ------------------------------------------------------------------
    task automatic emit_row_byte(input logic [7:0] value, inout int n);
        row_byte_t b;
        b.data        = value;
        b.row_end     = 1'b0;
        b.last_of_run = 1'b0;
        expected_bytes.push_back(b);
        mdl_mod4 = mdl_mod4 + 2'd1;
        n++;
    endtask

    task automatic pack_pixel(input logic [31:0] word);
        logic [9:0] sum;
        logic [9:0] avg;
        int         n;
        int         tail;
        n   = 0;
        sum = {2'b0, word[31:24]} + {2'b0, word[23:16]} + {2'b0, word[15:8]};
        avg = sum / 10'd3;

        // Set the pixel bit, emit when the byte is full
        if (avg > {2'b0, mdl_level})
            mdl_acc[mdl_bit] = 1'b1;
        if (mdl_bit == 3'd0)
        begin
            emit_row_byte(mdl_acc, n);
            mdl_acc = '0;
            mdl_bit = 3'd7;
        end
        else
            mdl_bit = mdl_bit - 3'd1;

        // Close the row: flush, pad to four bytes, mark the end
        mdl_col = mdl_col + 1'b1;
        if (mdl_col == COL_W'(mdl_width))
        begin
            if (mdl_bit != 3'd7)
            begin
                emit_row_byte(mdl_acc, n);
                mdl_acc = '0;
                mdl_bit = 3'd7;
            end
            while (mdl_mod4 != 2'd0)
                emit_row_byte(8'h00, n);
            if (n > 0)
                expected_bytes[expected_bytes.size()-1].row_end = 1'b1;
            mdl_col  = '0;
            mdl_mod4 = '0;
        end

        if (n > 0)
        begin
            tail = expected_bytes.size() - 1;
            expected_bytes[tail].last_of_run = 1'b1;
        end
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_THRESHOLD: mdl_level = value[7:0];
            REG_ROW_WIDTH: mdl_width = value[15:0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic add_pixel(input logic [31:0] word, input int gap);
        stim_job_t j;
        j.kind  = JOB_PIXEL;
        j.index = '0;
        j.data  = word;
        j.gap   = gap;
        jobs.push_back(j);
        gen_col = gen_col + 1'b1;
        if (gen_col == COL_W'(gen_width))
            gen_col = '0;
    endtask

    task automatic add_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        stim_job_t j;
        j.kind  = JOB_WRITE;
        j.index = idx;
        j.data  = 32'(value);
        j.gap   = draw_gap(tx_calm);
        jobs.push_back(j);
        if (idx == REG_THRESHOLD)
            gen_level = value[7:0];
        else if (idx == REG_ROW_WIDTH)
            gen_width = value;
    endtask

    task automatic add_drain();
        stim_job_t j;
        j.kind  = JOB_DRAIN;
        j.index = '0;
        j.data  = '0;
        j.gap   = 0;
        jobs.push_back(j);
    endtask

    // ------------------------------------------------------------------
    // Driver: pixel and register transfers from the job queue
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        bit nv;
        bit nc;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else
        begin
            nv = in_valid;
            nc = cfg_valid;

            // Retire accepted transfers into the model
            if (in_valid && in_ready)
            begin
                pack_pixel(pixel_word);
                pixels_sent++;
                nv   = 1'b0;
                hold = hold_after;
            end
            if (cfg_valid && cfg_ready)
            begin
                write_register(cfg_index, cfg_data);
                writes_done++;
                nc   = 1'b0;
                hold = hold_after;
            end

            // Count cycles with nothing outstanding
            if (expected_bytes.size() == 0 && !in_valid && !cfg_valid)
                quiet++;
            else
                quiet = 0;

            // Launch the next job once the previous one is gone
            if (!nv && !nc && jobs.size() != 0)
            begin
                if (hold > 0)
                    hold--;
                else
                begin
                    case (jobs[0].kind)
                        JOB_PIXEL:
                        begin
                            pixel_word <= jobs[0].data;
                            hold_after = jobs[0].gap;
                            nv = 1'b1;
                            void'(jobs.pop_front());
                        end
                        JOB_WRITE:
                        begin
                            if (quiet >= SETTLE_CYCLES)
                            begin
                                cfg_index <= jobs[0].index;
                                cfg_data  <= jobs[0].data[CFG_DATA_W-1:0];
                                hold_after = jobs[0].gap;
                                nc = 1'b1;
                                void'(jobs.pop_front());
                            end
                        end
                        default:
                        begin
                            // Hold off until every expected byte is out
                            if (expected_bytes.size() == 0)
                            begin
                                drains++;
                                void'(jobs.pop_front());
                            end
                        end
                    endcase
                end
            end

            in_valid  <= nv;
            cfg_valid <= nc;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each output transfer, stall at random
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        bit        nr;
        row_byte_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            nr = out_ready;
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                    report_mismatch("unexpected out_byte", out_byte, 0);
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want.data)
                        report_mismatch("out_byte", out_byte, want.data);
                    if (row_end !== want.row_end)
                        report_mismatch("row_end", row_end, want.row_end);
                    if (last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", last_of_run, want.last_of_run);
                end
                bytes_checked++;
                if (row_end === 1'b1)
                    rows_seen++;
                stall = draw_gap(rx_calm);
                nr = (stall == 0);
            end
            else if (!out_ready)
            begin
                if (stall > 0)
                    stall--;
                if (stall == 0)
                    nr = 1'b1;
            end
            out_ready <= nr;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int rand_pixels;
        int count;
        rand_pixels = 0;

        // Directed: reset settings give one pixel per row, four bytes each
        add_pixel(32'h0000_0000, draw_gap(tx_calm));
        add_pixel(32'hFFFF_FF00, draw_gap(tx_calm));
        add_pixel(32'h0000_00FF, draw_gap(tx_calm));   // only the ignored byte set
        add_pixel(32'h7F7F_7F00, draw_gap(tx_calm));   // average equals threshold
        add_pixel(32'h8080_8000, draw_gap(tx_calm));   // one above
        add_pixel(32'h8080_7F00, draw_gap(tx_calm));   // truncated average
        add_pixel(32'hFFFF_FFFF, draw_gap(tx_calm));

        // Threshold extremes, high data bits must be dropped
        add_write(REG_THRESHOLD, 16'hFF00);
        add_pixel(32'h0101_0100, draw_gap(tx_calm));
        add_pixel(32'h0100_0100, draw_gap(tx_calm));
        add_write(REG_THRESHOLD, 16'h00FF);
        add_pixel(32'hFFFF_FFFF, draw_gap(tx_calm));

        // Unknown indexes are ignored
        add_write(REG_SPARE_FIRST, 16'h0005);
        add_write(REG_SPARE_LAST, 16'hFFFF);

        // Nine-pixel row: one full byte, a one-bit flush, two pad bytes
        add_write(REG_THRESHOLD, 16'd127);
        add_write(REG_ROW_WIDTH, 16'd9);
        for (int i = 0; i < 9; i++)
            add_pixel((i % 2 == 0) ? 32'hFFFF_FF00 : 32'h0000_00FF, draw_gap(tx_calm));
        add_drain();

        // Width raised mid-row, ahead of the column
        add_write(REG_ROW_WIDTH, 16'd10);
        for (int i = 0; i < 6; i++)
            add_pixel($urandom, draw_gap(tx_calm));
        add_write(REG_ROW_WIDTH, 16'd12);
        for (int i = 6; i < 12; i++)
            add_pixel($urandom, draw_gap(tx_calm));

        // Random phases with settings changed between them
        while (rand_pixels < RANDOM_PIXELS)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: add_write(REG_THRESHOLD, 16'd0);
                    1: add_write(REG_THRESHOLD, 16'd255);
                    2: add_write(REG_THRESHOLD, 16'($urandom_range(0, 255)));
                    default: add_write(REG_THRESHOLD, 16'($urandom));
                endcase
            end
            if ($urandom_range(0, 2) == 0)
            begin
                if (gen_col != '0)
                    add_write(REG_ROW_WIDTH, 16'(gen_col + $urandom_range(1, 24)));
                else
                begin
                    case ($urandom_range(0, 3))
                        0: add_write(REG_ROW_WIDTH, 16'd1);
                        1: add_write(REG_ROW_WIDTH, 16'($urandom_range(2, 16)));
                        2: add_write(REG_ROW_WIDTH, 16'($urandom_range(17, 64)));
                        default: add_write(REG_ROW_WIDTH, 16'(8 * $urandom_range(1, 8)));
                    endcase
                end
            end
            if ($urandom_range(0, 9) == 0)
                add_write(CFG_INDEX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                          16'($urandom));
            if ($urandom_range(0, 7) == 0)
                add_drain();

            count = $urandom_range(4, 48);
            for (int i = 0; i < count; i++)
            begin
                if ($urandom_range(0, 1) == 0)
                    add_pixel($urandom, draw_gap(tx_calm));
                else
                    add_pixel(near_level(gen_level), draw_gap(tx_calm));
            end
            rand_pixels += count;
        end

        // Reset once
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Drain everything, then watch for stray output
        while (jobs.size() != 0 || in_valid || cfg_valid || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (4 * SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d pixels and %0d register writes;",
                 pixels_sent, writes_done);
        $display("%0d bytes in %0d rows checked, %0d full drains, mid-row width raises.",
                 bytes_checked, rows_seen, drains);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("ERROR: timeout with %0d jobs and %0d bytes pending",
                 jobs.size(), expected_bytes.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
sv/thbp_pkg.sv
sv/thbp_pack.sv
sv/thbp_emit.sv
sv/threshold_binarize_pack_1bpp.sv
verif/tb.sv
